@@ hdl/lav_pkg.sv @@
// ----------------------------------------------------------------------------
// lav_pkg: shared constants for the look-at view matrix block
// Fixed widths of the beat fields and of the root and divide cell chains.
// ----------------------------------------------------------------------------
`default_nettype none

package lav_pkg;

    localparam int FRAC_BITS_DEF = 16;  // default fraction bits (Q16.16)
    localparam int POS_W         = 32;  // position, aim and up components
    localparam int FIELD_W       = 18;  // vector result fields
    localparam int M_W           = 30;  // normalized magnitude width
    localparam int ROOT_W        = 64;  // radicand and root working width
    localparam int ROOT_STEPS    = 32;  // one result bit per root cell
    localparam int RT_W          = 31;  // width of the vector length

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

endpackage

`default_nettype wire

@@ hdl/lav_if.sv @@
// ----------------------------------------------------------------------------
// lav_if: valid/ready channels of the look-at view matrix block
// Input beat carries eye, aim and up; output beat carries the view matrix.
// ----------------------------------------------------------------------------
`default_nettype none

interface lav_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] aim_x;
    logic signed [31:0] aim_y;
    logic signed [31:0] aim_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;

    modport source (
        output valid, op, pos_x, pos_y, pos_z, aim_x, aim_y, aim_z, up_x, up_y, up_z,
        input  ready
    );
    modport sink (
        input  valid, op, pos_x, pos_y, pos_z, aim_x, aim_y, aim_z, up_x, up_y, up_z,
        output ready
    );
endinterface

interface lav_out_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] right_x;
    logic signed [17:0] right_y;
    logic signed [17:0] right_z;
    logic signed [17:0] upward_x;
    logic signed [17:0] upward_y;
    logic signed [17:0] upward_z;
    logic signed [17:0] forward_x;
    logic signed [17:0] forward_y;
    logic signed [17:0] forward_z;
    logic signed [31:0] shift_u;
    logic signed [31:0] shift_v;
    logic signed [31:0] shift_w;

    modport source (
        output valid, right_x, right_y, right_z, upward_x, upward_y, upward_z,
               forward_x, forward_y, forward_z, shift_u, shift_v, shift_w,
        input  ready
    );
    modport sink (
        input  valid, right_x, right_y, right_z, upward_x, upward_y, upward_z,
               forward_x, forward_y, forward_z, shift_u, shift_v, shift_w,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/lav_root_cell.sv @@
// ----------------------------------------------------------------------------
// lav_root_cell: one step of a digit-by-digit integer square root
// Try the result bit of weight 2^K (trial term 4^K), register remainder, root and tag.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_root_cell import lav_pkg::*; #(
    parameter int K  = 0,
    parameter int TW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [ROOT_W-1:0] i_n,
    input  logic [ROOT_W-1:0] i_res,
    input  logic [TW-1:0]     i_tag,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_n,
    output logic [ROOT_W-1:0] o_res,
    output logic [TW-1:0]     o_tag
);

    localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * K);

    logic              r_valid;
    logic [ROOT_W-1:0] r_n;
    logic [ROOT_W-1:0] r_res;
    logic [TW-1:0]     r_tag;
    logic [ROOT_W-1:0] n_try;

    assign n_try = i_res + BIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag <= i_tag;
            if (i_n >= n_try) begin
                r_n   <= i_n - n_try;
                r_res <= (i_res >> 1) + BIT;
            end else begin
                r_n   <= i_n;
                r_res <= i_res >> 1;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_n     = r_n;
    assign o_res   = r_res;
    assign o_tag   = r_tag;

endmodule

`default_nettype wire

@@ hdl/lav_div_cell.sv @@
// ----------------------------------------------------------------------------
// lav_div_cell: one quotient bit of a three-lane restoring divider
// Compare each numerator with the divisor at weight 2^J, subtract on success.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_div_cell import lav_pkg::*; #(
    parameter int J  = 0,
    parameter int NB = 48,
    parameter int QW = 17,
    parameter int TW = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2:0][NB-1:0]    i_num,
    input  logic [2:0][QW-1:0]    i_q,
    input  logic [RT_W-1:0]       i_r,
    input  logic [TW-1:0]         i_tag,
    output logic                  o_valid,
    output logic [2:0][NB-1:0]    o_num,
    output logic [2:0][QW-1:0]    o_q,
    output logic [RT_W-1:0]       o_r,
    output logic [TW-1:0]         o_tag
);

    logic               r_valid;
    logic [2:0][NB-1:0] r_num;
    logic [2:0][QW-1:0] r_q;
    logic [RT_W-1:0]    r_r;
    logic [TW-1:0]      r_tag;
    logic [NB-1:0]      n_rs;

    assign n_rs = NB'(i_r) << J;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r   <= i_r;
            r_tag <= i_tag;
            for (int i = 0; i < 3; i++) begin
                if (i_num[i] >= n_rs) begin
                    r_num[i] <= i_num[i] - n_rs;
                    r_q[i]   <= i_q[i] | (QW'(1) << J);
                end else begin
                    r_num[i] <= i_num[i];
                    r_q[i]   <= i_q[i];
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_q     = r_q;
    assign o_r     = r_r;
    assign o_tag   = r_tag;

endmodule

`default_nettype wire

@@ hdl/lav_norm.sv @@
// ----------------------------------------------------------------------------
// lav_norm: pipelined 3-vector normalizer
// Scale by a common power of two, sum squares, take the root through a chain
// of root cells, divide each lane through a chain of divide cells.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_norm import lav_pkg::*; #(
    parameter int IW = 33,
    parameter int FB = FRAC_BITS_DEF,
    parameter int TW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [2:0][IW-1:0]   i_a,
    input  logic [TW-1:0]        i_tag,
    output logic                 o_valid,
    output logic [2:0][FB+1:0]   o_q,
    output logic [TW-1:0]        o_tag
);

    localparam int MW  = IW;
    localparam int NS  = $clog2(MW);
    localparam int SW  = TW + 4;          // tag, zero flag, three signs
    localparam int RTW = SW + 3 * M_W;
    localparam int NB  = FB + 32;
    localparam int QW  = FB + 1;

    // magnitude and shift stages
    logic [NS:0]        r_sv;
    logic [2:0][MW-1:0] r_sm [NS+1];
    logic [SW-1:0]      r_ss [NS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (i_en) begin
            r_sv[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sm[0][i] <= i_a[i][IW-1] ? (~i_a[i] + 1'b1) : i_a[i];
            end
            r_ss[0] <= {i_tag, (i_a == '0), i_a[2][IW-1], i_a[1][IW-1], i_a[0][IW-1]};
        end
    end

    for (genvar s = 1; s <= NS; s++) begin : g_shift
        localparam int A = 1 << (NS - s);
        logic [MW-1:0] n_or;
        logic          n_go;

        assign n_or = r_sm[s-1][0] | r_sm[s-1][1] | r_sm[s-1][2];
        assign n_go = (n_or[MW-1 -: A] == '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[s] <= 1'b0;
            end else if (i_en) begin
                r_sv[s] <= r_sv[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_sm[s][i] <= n_go ? (r_sm[s-1][i] << A) : r_sm[s-1][i];
                end
                r_ss[s] <= r_ss[s-1];
            end
        end
    end

    // squares, then their sum
    logic [2:0][M_W-1:0]   n_m30;
    logic                  r_sq_v;
    logic [2:0][2*M_W-1:0] r_sq;
    logic [2:0][M_W-1:0]   r_sq_m;
    logic [SW-1:0]         r_sq_s;
    logic                  r_sum_v;
    logic [ROOT_W-1:0]     r_len2;
    logic [2:0][M_W-1:0]   r_sum_m;
    logic [SW-1:0]         r_sum_s;

    for (genvar i = 0; i < 3; i++) begin : g_trunc
        assign n_m30[i] = r_sm[NS][i][MW-1 -: M_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v  <= 1'b0;
            r_sum_v <= 1'b0;
        end else if (i_en) begin
            r_sq_v  <= r_sv[NS];
            r_sum_v <= r_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= (2*M_W)'(n_m30[i]) * (2*M_W)'(n_m30[i]);
            end
            r_sq_m  <= n_m30;
            r_sq_s  <= r_ss[NS];
            r_len2  <= ROOT_W'(r_sq[0]) + ROOT_W'(r_sq[1]) + ROOT_W'(r_sq[2]);
            r_sum_m <= r_sq_m;
            r_sum_s <= r_sq_s;
        end
    end

    // square root chain
    logic [ROOT_STEPS:0] w_rv;
    logic [ROOT_W-1:0]   w_rn [ROOT_STEPS+1];
    logic [ROOT_W-1:0]   w_rr [ROOT_STEPS+1];
    logic [RTW-1:0]      w_rt [ROOT_STEPS+1];

    assign w_rv[0] = r_sum_v;
    assign w_rn[0] = r_len2;
    assign w_rr[0] = '0;
    assign w_rt[0] = {r_sum_s, r_sum_m};

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
        lav_root_cell #(
            .K  (ROOT_STEPS - 1 - k),
            .TW (RTW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_rv[k]),
            .i_n     (w_rn[k]),
            .i_res   (w_rr[k]),
            .i_tag   (w_rt[k]),
            .o_valid (w_rv[k+1]),
            .o_n     (w_rn[k+1]),
            .o_res   (w_rr[k+1]),
            .o_tag   (w_rt[k+1])
        );
    end

    // numerators: m * 2^FB + r / 2
    logic [SW-1:0]       n_rs;
    logic [2:0][M_W-1:0] n_rm;
    logic [RT_W-1:0]     n_len;
    logic                r_nm_v;
    logic [2:0][NB-1:0]  r_nm_num;
    logic [RT_W-1:0]     r_nm_r;
    logic [SW-1:0]       r_nm_s;

    assign {n_rs, n_rm} = w_rt[ROOT_STEPS];
    assign n_len        = w_rr[ROOT_STEPS][RT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm_v <= 1'b0;
        end else if (i_en) begin
            r_nm_v <= w_rv[ROOT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_nm_num[i] <= (NB'(n_rm[i]) << FB) + NB'(n_len >> 1);
            end
            r_nm_r <= n_len;
            r_nm_s <= n_rs;
        end
    end

    // divide chain, quotient MSB first
    logic [FB+1:0]      w_dv;
    logic [2:0][NB-1:0] w_dn [FB+2];
    logic [2:0][QW-1:0] w_dq [FB+2];
    logic [RT_W-1:0]    w_dr [FB+2];
    logic [SW-1:0]      w_ds [FB+2];

    assign w_dv[0] = r_nm_v;
    assign w_dn[0] = r_nm_num;
    assign w_dq[0] = '0;
    assign w_dr[0] = r_nm_r;
    assign w_ds[0] = r_nm_s;

    for (genvar j = 0; j <= FB; j++) begin : g_div
        lav_div_cell #(
            .J  (FB - j),
            .NB (NB),
            .QW (QW),
            .TW (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_dv[j]),
            .i_num   (w_dn[j]),
            .i_q     (w_dq[j]),
            .i_r     (w_dr[j]),
            .i_tag   (w_ds[j]),
            .o_valid (w_dv[j+1]),
            .o_num   (w_dn[j+1]),
            .o_q     (w_dq[j+1]),
            .o_r     (w_dr[j+1]),
            .o_tag   (w_ds[j+1])
        );
    end

    // apply signs; a zero vector gives zero
    logic                r_o_v;
    logic [2:0][FB+1:0]  r_o_q;
    logic [TW-1:0]       r_o_t;
    logic [SW-1:0]       n_fs;
    logic [2:0][FB+1:0]  n_mag;

    assign n_fs = w_ds[FB+1];

    for (genvar i = 0; i < 3; i++) begin : g_ext
        assign n_mag[i] = {1'b0, w_dq[FB+1][i]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (i_en) begin
            r_o_v <= w_dv[FB+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (n_fs[3]) begin
                    r_o_q[i] <= '0;
                end else if (n_fs[i]) begin
                    r_o_q[i] <= ~n_mag[i] + 1'b1;
                end else begin
                    r_o_q[i] <= n_mag[i];
                end
            end
            r_o_t <= n_fs[SW-1:4];
        end
    end

    assign o_valid = r_o_v;
    assign o_q     = r_o_q;
    assign o_tag   = r_o_t;

endmodule

`default_nettype wire

@@ hdl/look_at_view_matrix.sv @@
// ----------------------------------------------------------------------------
// look_at_view_matrix: fixed-point camera view matrix (look-at)
// Throughput: one beat per cycle; the whole chain advances on a common enable,
// so a stalled output register holds every stage in place.
// Each of the two normalizers holds 32 root cells and FRAC_BITS + 1 divide cells.
// Reset: synchronous, active low; clears every stage valid bit, payload keeps.
// ----------------------------------------------------------------------------
`default_nettype none

module look_at_view_matrix import lav_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lav_in_if.sink    i_in,
    lav_out_if.source o_out
);

    localparam int FB   = FRAC_BITS;
    localparam int WW   = FB + 2;        // unit vector component
    localparam int DW   = POS_W + 1;     // direction component
    localparam int CW   = FB + 34;       // cross product w x up
    localparam int PRW  = WW + POS_W;    // component times position
    localparam int SUMW = PRW + 2;       // dot product
    localparam int VPW  = 2 * WW;        // w times u
    localparam int VDW  = VPW + 1;       // raw v component
    localparam int T1W  = 6 * POS_W;     // p and up riding through normalizer 1
    localparam int T2W  = 3 * WW + 3 * POS_W;

    localparam logic [SUMW-1:0]       HALF_S = SUMW'(1) << (FB - 1);
    localparam logic [VDW-1:0]        HALF_V = VDW'(1) << (FB - 1);
    localparam logic [VDW-1:0]        ONE_V  = VDW'(1) << FB;
    localparam logic signed [WW-1:0]  ONE_W  = WW'(1) << FB;
    localparam logic [SUMW-1:0]       LIM_P  = SUMW'(SAT_MAX);
    localparam logic [SUMW-1:0]       LIM_N  = SUMW'(SAT_MIN);

    // -(x / 2^FB) rounded half away from zero, saturated to 32 bits
    function automatic logic [31:0] neg_round_sat(input logic signed [SUMW-1:0] x);
        logic [SUMW-1:0] mag;
        logic [SUMW-1:0] q;
        logic [31:0]     res;
        mag = x[SUMW-1] ? (~x + 1'b1) : x;
        q   = (mag + HALF_S) >> FB;
        if (x[SUMW-1]) begin
            res = (q > LIM_P) ? SAT_MAX : q[31:0];
        end else begin
            res = (q > LIM_N) ? SAT_MIN : (~q[31:0] + 1'b1);
        end
        return res;
    endfunction

    // x / 2^FB rounded half away from zero, clamped to +-1.0
    function automatic logic [WW-1:0] v_round(input logic signed [VDW-1:0] x);
        logic [VDW-1:0] mag;
        logic [VDW-1:0] q;
        logic [WW-1:0]  qn;
        mag = x[VDW-1] ? (~x + 1'b1) : x;
        q   = (mag + HALF_V) >> FB;
        if (q > ONE_V) begin
            q = ONE_V;
        end
        qn = q[WW-1:0];
        return x[VDW-1] ? (~qn + 1'b1) : qn;
    endfunction

    // one enable for the whole chain: advance unless the result beat is stuck
    logic en;
    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // ---------------------------------------------------------------------
    // Input stage: form the direction (aim, or aim minus eye when op is set)
    // ---------------------------------------------------------------------
    logic [2:0][POS_W-1:0] n_pos;
    logic [2:0][POS_W-1:0] n_aim;
    logic [2:0][POS_W-1:0] n_up;
    logic [2:0][DW-1:0]    n_dir;

    assign n_pos = {i_in.pos_z, i_in.pos_y, i_in.pos_x};
    assign n_aim = {i_in.aim_z, i_in.aim_y, i_in.aim_x};
    assign n_up  = {i_in.up_z,  i_in.up_y,  i_in.up_x};

    for (genvar i = 0; i < 3; i++) begin : g_dir
        assign n_dir[i] = i_in.op
            ? DW'($signed(n_aim[i])) - DW'($signed(n_pos[i]))
            : DW'($signed(n_aim[i]));
    end

    logic                  r_s0_v;
    logic [2:0][DW-1:0]    r_s0_d;
    logic [2:0][POS_W-1:0] r_s0_p;
    logic [2:0][POS_W-1:0] r_s0_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_d  <= n_dir;
            r_s0_p  <= n_pos;
            r_s0_up <= n_up;
        end
    end

    // ---------------------------------------------------------------------
    // Normalizer 1: w = d / |d|
    // ---------------------------------------------------------------------
    logic                  w1_v;
    logic [2:0][WW-1:0]    w1_w;
    logic [T1W-1:0]        w1_t;

    lav_norm #(
        .IW (DW),
        .FB (FB),
        .TW (T1W)
    ) u_norm_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s0_v),
        .i_a     (r_s0_d),
        .i_tag   ({r_s0_up, r_s0_p}),
        .o_valid (w1_v),
        .o_q     (w1_w),
        .o_tag   (w1_t)
    );

    logic [2:0][POS_W-1:0] n_c_p;
    logic [2:0][POS_W-1:0] n_c_up;
    assign {n_c_up, n_c_p} = w1_t;

    // ---------------------------------------------------------------------
    // Cross product w x up: products, then differences
    // ---------------------------------------------------------------------
    logic                  r_c1_v;
    logic signed [PRW-1:0] r_c1_pr [6];
    logic [2:0][WW-1:0]    r_c1_w;
    logic [2:0][POS_W-1:0] r_c1_p;
    logic                  r_c2_v;
    logic signed [CW-1:0]  r_c2_c [3];
    logic [2:0][WW-1:0]    r_c2_w;
    logic [2:0][POS_W-1:0] r_c2_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_v <= 1'b0;
            r_c2_v <= 1'b0;
        end else if (en) begin
            r_c1_v <= w1_v;
            r_c2_v <= r_c1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1_pr[0] <= $signed(w1_w[1]) * $signed(n_c_up[2]);
            r_c1_pr[1] <= $signed(w1_w[2]) * $signed(n_c_up[1]);
            r_c1_pr[2] <= $signed(w1_w[2]) * $signed(n_c_up[0]);
            r_c1_pr[3] <= $signed(w1_w[0]) * $signed(n_c_up[2]);
            r_c1_pr[4] <= $signed(w1_w[0]) * $signed(n_c_up[1]);
            r_c1_pr[5] <= $signed(w1_w[1]) * $signed(n_c_up[0]);
            r_c1_w     <= w1_w;
            r_c1_p     <= n_c_p;
            r_c2_c[0]  <= r_c1_pr[0] - r_c1_pr[1];
            r_c2_c[1]  <= r_c1_pr[2] - r_c1_pr[3];
            r_c2_c[2]  <= r_c1_pr[4] - r_c1_pr[5];
            r_c2_w     <= r_c1_w;
            r_c2_p     <= r_c1_p;
        end
    end

    // ---------------------------------------------------------------------
    // Normalizer 2: u = c / |c|
    // ---------------------------------------------------------------------
    logic [2:0][CW-1:0]    n_c;
    logic                  w2_v;
    logic [2:0][WW-1:0]    w2_u;
    logic [T2W-1:0]        w2_t;

    assign n_c = {r_c2_c[2], r_c2_c[1], r_c2_c[0]};

    lav_norm #(
        .IW (CW),
        .FB (FB),
        .TW (T2W)
    ) u_norm_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c2_v),
        .i_a     (n_c),
        .i_tag   ({r_c2_w, r_c2_p}),
        .o_valid (w2_v),
        .o_q     (w2_u),
        .o_tag   (w2_t)
    );

    logic [2:0][WW-1:0]    n_v_w;
    logic [2:0][POS_W-1:0] n_v_p;
    assign {n_v_w, n_v_p} = w2_t;

    // ---------------------------------------------------------------------
    // v = w x u and the three translations
    // ---------------------------------------------------------------------
    logic                   r_v1_v;
    logic signed [VPW-1:0]  r_v1_wu [6];
    logic signed [PRW-1:0]  r_v1_up [3];
    logic signed [PRW-1:0]  r_v1_wp [3];
    logic [2:0][WW-1:0]     r_v1_u;
    logic [2:0][WW-1:0]     r_v1_w;
    logic [2:0][POS_W-1:0]  r_v1_p;

    logic signed [VDW-1:0]  n_vraw [3];
    logic                   r_v2_v;
    logic [2:0][WW-1:0]     r_v2_vv;
    logic signed [SUMW-1:0] r_v2_su;
    logic signed [SUMW-1:0] r_v2_sw;
    logic [2:0][WW-1:0]     r_v2_u;
    logic [2:0][WW-1:0]     r_v2_w;
    logic [2:0][POS_W-1:0]  r_v2_p;

    logic                   r_v3_v;
    logic signed [PRW-1:0]  r_v3_pv [3];
    logic [31:0]            r_v3_shu;
    logic [31:0]            r_v3_shw;
    logic [2:0][WW-1:0]     r_v3_u;
    logic [2:0][WW-1:0]     r_v3_vv;
    logic [2:0][WW-1:0]     r_v3_w;

    logic                   r_v4_v;
    logic signed [SUMW-1:0] r_v4_sv;
    logic [31:0]            r_v4_shu;
    logic [31:0]            r_v4_shw;
    logic [2:0][WW-1:0]     r_v4_u;
    logic [2:0][WW-1:0]     r_v4_vv;
    logic [2:0][WW-1:0]     r_v4_w;

    logic                   r_o_valid;
    logic signed [WW-1:0]   r_o_u [3];
    logic signed [WW-1:0]   r_o_v [3];
    logic signed [WW-1:0]   r_o_w [3];
    logic [31:0]            r_o_sh [3];

    assign n_vraw[0] = r_v1_wu[0] - r_v1_wu[1];
    assign n_vraw[1] = r_v1_wu[2] - r_v1_wu[3];
    assign n_vraw[2] = r_v1_wu[4] - r_v1_wu[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1_v    <= 1'b0;
            r_v2_v    <= 1'b0;
            r_v3_v    <= 1'b0;
            r_v4_v    <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_v1_v    <= w2_v;
            r_v2_v    <= r_v1_v;
            r_v3_v    <= r_v2_v;
            r_v4_v    <= r_v3_v;
            r_o_valid <= r_v4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // products of w, u and the eye position
            r_v1_wu[0] <= $signed(n_v_w[1]) * $signed(w2_u[2]);
            r_v1_wu[1] <= $signed(n_v_w[2]) * $signed(w2_u[1]);
            r_v1_wu[2] <= $signed(n_v_w[2]) * $signed(w2_u[0]);
            r_v1_wu[3] <= $signed(n_v_w[0]) * $signed(w2_u[2]);
            r_v1_wu[4] <= $signed(n_v_w[0]) * $signed(w2_u[1]);
            r_v1_wu[5] <= $signed(n_v_w[1]) * $signed(w2_u[0]);
            for (int i = 0; i < 3; i++) begin
                r_v1_up[i] <= $signed(w2_u[i])  * $signed(n_v_p[i]);
                r_v1_wp[i] <= $signed(n_v_w[i]) * $signed(n_v_p[i]);
            end
            r_v1_u <= w2_u;
            r_v1_w <= n_v_w;
            r_v1_p <= n_v_p;

            // round and clamp v, sum the u and w dots
            for (int i = 0; i < 3; i++) begin
                r_v2_vv[i] <= v_round(n_vraw[i]);
            end
            r_v2_su <= r_v1_up[0] + r_v1_up[1] + r_v1_up[2];
            r_v2_sw <= r_v1_wp[0] + r_v1_wp[1] + r_v1_wp[2];
            r_v2_u  <= r_v1_u;
            r_v2_w  <= r_v1_w;
            r_v2_p  <= r_v1_p;

            // v dot products; finish the u and w translations
            for (int i = 0; i < 3; i++) begin
                r_v3_pv[i] <= $signed(r_v2_vv[i]) * $signed(r_v2_p[i]);
            end
            r_v3_shu <= neg_round_sat(r_v2_su);
            r_v3_shw <= neg_round_sat(r_v2_sw);
            r_v3_u   <= r_v2_u;
            r_v3_vv  <= r_v2_vv;
            r_v3_w   <= r_v2_w;

            r_v4_sv  <= r_v3_pv[0] + r_v3_pv[1] + r_v3_pv[2];
            r_v4_shu <= r_v3_shu;
            r_v4_shw <= r_v3_shw;
            r_v4_u   <= r_v3_u;
            r_v4_vv  <= r_v3_vv;
            r_v4_w   <= r_v3_w;

            // output register
            for (int i = 0; i < 3; i++) begin
                r_o_u[i] <= r_v4_u[i];
                r_o_v[i] <= r_v4_vv[i];
                r_o_w[i] <= r_v4_w[i];
            end
            r_o_sh[0] <= r_v4_shu;
            r_o_sh[1] <= neg_round_sat(r_v4_sv);
            r_o_sh[2] <= r_v4_shw;
        end
    end

    // vector fields carry the low bits of the sign-extended component
    assign o_out.valid     = r_o_valid;
    assign o_out.right_x   = FIELD_W'(r_o_u[0]);
    assign o_out.right_y   = FIELD_W'(r_o_u[1]);
    assign o_out.right_z   = FIELD_W'(r_o_u[2]);
    assign o_out.upward_x  = FIELD_W'(r_o_v[0]);
    assign o_out.upward_y  = FIELD_W'(r_o_v[1]);
    assign o_out.upward_z  = FIELD_W'(r_o_v[2]);
    assign o_out.forward_x = FIELD_W'(r_o_w[0]);
    assign o_out.forward_y = FIELD_W'(r_o_w[1]);
    assign o_out.forward_z = FIELD_W'(r_o_w[2]);
    assign o_out.shift_u   = r_o_sh[0];
    assign o_out.shift_v   = r_o_sh[1];
    assign o_out.shift_w   = r_o_sh[2];

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_w_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |->
            (r_o_w[0] <= ONE_W) && (r_o_w[0] >= -ONE_W) &&
            (r_o_w[1] <= ONE_W) && (r_o_w[1] >= -ONE_W) &&
            (r_o_w[2] <= ONE_W) && (r_o_w[2] >= -ONE_W))
        else $error("forward component beyond unit range");

    a_v_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |->
            (r_o_v[0] <= ONE_W) && (r_o_v[0] >= -ONE_W) &&
            (r_o_v[1] <= ONE_W) && (r_o_v[1] >= -ONE_W) &&
            (r_o_v[2] <= ONE_W) && (r_o_v[2] >= -ONE_W))
        else $error("upward component escaped its clamp");

    a_zero_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_w[0] == '0 && r_o_w[1] == '0 && r_o_w[2] == '0) |->
            (r_o_u[0] == '0 && r_o_u[1] == '0 && r_o_u[2] == '0 &&
             r_o_v[0] == '0 && r_o_v[1] == '0 && r_o_v[2] == '0 &&
             r_o_sh[0] == '0 && r_o_sh[1] == '0 && r_o_sh[2] == '0))
        else $error("zero forward vector left a nonzero result");

endmodule

`default_nettype wire
